@@ rtl/rbm_pkg.sv @@
// Shared types and constants for the ROM bank mapper with IRQ counter.
`timescale 1ns / 1ps

package rbm_pkg;

    typedef enum logic [1:0] {
        OP_CPU_WRITE  = 2'd0,
        OP_CPU_TICK   = 2'd1,
        OP_CPU_LOOKUP = 2'd2,
        OP_PPU_LOOKUP = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REGION_UNMAPPED = 2'd0,
        REGION_PRG_ROM  = 2'd1,
        REGION_PRG_RAM  = 2'd2,
        REGION_CHR_ROM  = 2'd3
    } region_t;

    typedef enum logic [1:0] {
        MIRROR_VERTICAL   = 2'd0,
        MIRROR_HORIZONTAL = 2'd1,
        MIRROR_SINGLE_LOW = 2'd2
    } mirror_t;

    localparam logic [3:0] PAGE_PRG0 = 4'h8;
    localparam logic [3:0] PAGE_MISC = 4'h9;
    localparam logic [3:0] PAGE_PRG1 = 4'hA;
    localparam logic [3:0] PAGE_CHR  = 4'hB;

    localparam logic [2:0] SEL_SWAP_MODE = 3'd0;
    localparam logic [2:0] SEL_MIRROR    = 3'd1;
    localparam logic [2:0] SEL_IRQ_EN    = 3'd3;
    localparam logic [2:0] SEL_RELOAD    = 3'd4;
    localparam logic [2:0] SEL_LATCH_HI  = 3'd5;
    localparam logic [2:0] SEL_LATCH_LO  = 3'd6;

    localparam logic [1:0] MIRROR_BITS_VERT = 2'd0;
    localparam logic [1:0] MIRROR_BITS_HORZ = 2'd2;

    localparam logic [7:0]  FIXED_BANK_LOW  = 8'hFE;
    localparam logic [7:0]  FIXED_BANK_HIGH = 8'hFF;
    localparam logic [15:0] PRG_RAM_BASE    = 16'h6000;
    localparam logic [15:0] PRG_ROM_BASE    = 16'h8000;
    localparam logic [15:0] PPU_LIMIT       = 16'h2000;

    localparam int unsigned NUM_CHR = 8;

endpackage

@@ rtl/rom_bank_mapper_with_irq_counter_core.sv @@
// Top level: bank mapper register file, IRQ down counter and address lookup.
// Each accepted item's result is registered in the output register.
// Throughput: one item per cycle; the output register is the only stage, and
// s_tready stays high whenever that register is empty or being drained.
// Reset: synchronous active-low aresetn restores all bank, mirroring and IRQ
// state to its power-up values and empties the output register.
`timescale 1ns / 1ps

module rom_bank_mapper_with_irq_counter_core
    import rbm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] bank_number, [8] irq_line, [10:9] mirror_mode,
                                   // [15:11] zero
    output logic [1:0]  m_tuser    // [1:0] region
);

    logic        swap_reg,    swap_next;
    logic [7:0]  prg_reg [2];
    logic [7:0]  prg_next [2];
    logic [7:0]  chr_reg [NUM_CHR];
    logic [7:0]  chr_next [NUM_CHR];
    logic [1:0]  mirror_reg,  mirror_next;
    logic        irq_en_reg,  irq_en_next;
    logic [15:0] count_reg,   count_next;
    logic [15:0] latch_reg,   latch_next;
    logic        irq_reg,     irq_next;

    logic        out_valid_reg;
    region_t     out_region_reg, out_region_next;
    logic [7:0]  out_bank_reg,   out_bank_next;
    logic        out_irq_reg;
    mirror_t     out_mirror_reg, out_mirror_next;

    opcode_t     op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [3:0]  page;
    logic [2:0]  sel;
    logic [15:0] count_dec;
    logic        accept;

    assign op     = opcode_t'(s_tuser);
    assign addr   = s_tdata[15:0];
    assign data   = s_tdata[23:16];
    assign page   = addr[15:12];
    assign sel    = addr[2:0];
    assign count_dec = count_reg - 16'd1;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        swap_next   = swap_reg;
        prg_next    = prg_reg;
        chr_next    = chr_reg;
        mirror_next = mirror_reg;
        irq_en_next = irq_en_reg;
        count_next  = count_reg;
        latch_next  = latch_reg;
        irq_next    = irq_reg;
        out_region_next = REGION_UNMAPPED;
        out_bank_next   = 8'd0;

        case (op)
            OP_CPU_WRITE: begin
                case (page)
                    PAGE_PRG0, PAGE_PRG1: begin
                        prg_next[addr[13]] = data;
                    end
                    PAGE_CHR: begin
                        chr_next[sel] = data;
                    end
                    PAGE_MISC: begin
                        case (sel)
                            SEL_SWAP_MODE: swap_next = data[7];
                            SEL_MIRROR:    mirror_next = data[7:6];
                            SEL_IRQ_EN: begin
                                irq_en_next = data[7];
                                irq_next    = 1'b0;
                            end
                            SEL_RELOAD: begin
                                count_next = latch_reg;
                                irq_next   = 1'b0;
                            end
                            SEL_LATCH_HI:  latch_next = {data, latch_reg[7:0]};
                            SEL_LATCH_LO:  latch_next = {latch_reg[15:8], data};
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            OP_CPU_TICK: begin
                if (irq_en_reg) begin
                    count_next = count_dec;
                    if (count_dec == 16'd0) begin
                        irq_next    = 1'b1;
                        irq_en_next = 1'b0;
                    end
                end
            end
            OP_CPU_LOOKUP: begin
                if (addr < PRG_RAM_BASE) begin
                    out_region_next = REGION_UNMAPPED;
                end else if (addr < PRG_ROM_BASE) begin
                    out_region_next = REGION_PRG_RAM;
                end else begin
                    out_region_next = REGION_PRG_ROM;
                    case (addr[14:13])
                        2'd0:    out_bank_next = swap_reg ? FIXED_BANK_LOW : prg_reg[0];
                        2'd1:    out_bank_next = prg_reg[1];
                        2'd2:    out_bank_next = swap_reg ? prg_reg[0] : FIXED_BANK_LOW;
                        default: out_bank_next = FIXED_BANK_HIGH;
                    endcase
                end
            end
            OP_PPU_LOOKUP: begin
                if (addr < PPU_LIMIT) begin
                    out_region_next = REGION_CHR_ROM;
                    out_bank_next   = chr_reg[addr[12:10]];
                end
            end
            default: ;
        endcase

        case (mirror_next)
            MIRROR_BITS_VERT: out_mirror_next = MIRROR_VERTICAL;
            MIRROR_BITS_HORZ: out_mirror_next = MIRROR_HORIZONTAL;
            default:          out_mirror_next = MIRROR_SINGLE_LOW;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swap_reg      <= 1'b0;
            prg_reg[0]    <= 8'd0;
            prg_reg[1]    <= 8'd1;
            for (int i = 0; i < NUM_CHR; i++) begin
                chr_reg[i] <= 8'(i);
            end
            mirror_reg    <= 2'd0;
            irq_en_reg    <= 1'b0;
            count_reg     <= 16'd0;
            latch_reg     <= 16'd0;
            irq_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                swap_reg   <= swap_next;
                prg_reg    <= prg_next;
                chr_reg    <= chr_next;
                mirror_reg <= mirror_next;
                irq_en_reg <= irq_en_next;
                count_reg  <= count_next;
                latch_reg  <= latch_next;
                irq_reg    <= irq_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until taken
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_region_reg <= out_region_next;
            out_bank_reg   <= out_bank_next;
            out_irq_reg    <= irq_next;
            out_mirror_reg <= out_mirror_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_region_reg;
    assign m_tdata  = {5'd0, out_mirror_reg, out_irq_reg, out_bank_reg};

endmodule
